/* rtl/core/tkft_pkg.sv */
// Shared types and constants for the top-K frequency tracker.
// Holds the field widths, the reset value of the report length and the
// command/status structs that join the controller and the datapath.
package tkft_pkg;

  localparam int VALUE_RANGE_DEF = 1024;
  localparam int MAX_K_DEF       = 16;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int VAL_W       = 10;
  localparam int CNT_OUT_W   = 16;
  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CFG_W-1:0] K_RESET = 5'd16;

  typedef struct packed {
    logic load;       // capture the input beat, start the count-table read
    logic clr_write;  // zero one count-table entry, advance the sweep
    logic update;     // bump the count, place the value in the list
    logic bubble;     // one step of moving the placed entry forward
    logic emit;       // load the next ranked entry into the output register
  } tkft_cmd_t;

  typedef struct packed {
    logic in_range;   // input sample is below the value range
    logic clr_last;   // sweep is at the final entry
    logic placed;     // update changed the list, a bubble pass follows
    logic swap;       // the tracked entry outranks its predecessor
    logic emit_none;  // nothing to report
    logic emit_last;  // current rank is the final one reported
    logic out_free;   // output register can take a beat
  } tkft_stat_t;

endpackage

/* rtl/core/tkft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tkft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/tkft_dp.sv */
// Datapath of the top-K frequency tracker: count table RAM, sorted top list,
// report-length register and output register. Uses tkft_pkg and tkft_ram.
module tkft_dp
  import tkft_pkg::*;
#(
  parameter int VALUE_RANGE = VALUE_RANGE_DEF,
  parameter int MAX_K       = MAX_K_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tkft_cmd_t              cmd,
  output tkft_stat_t             st,
  input  logic [VAL_W-1:0]       in_sample,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int AW    = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
  localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int OCC_W = $clog2(MAX_K + 1);
  localparam int CW    = COUNT_BITS;
  localparam int PAD_W = OUT_TDATA_W - CNT_OUT_W - VAL_W;
  localparam logic [CW-1:0]    COUNT_MAX = {CW{1'b1}};
  localparam logic [AW-1:0]    CLR_END   = AW'(VALUE_RANGE - 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(MAX_K);
  localparam logic [IDX_W-1:0] IDX_TAIL  = IDX_W'(MAX_K - 1);

  function automatic logic ranks_before(input logic [CW-1:0] ca, input logic [VAL_W-1:0] va,
                                        input logic [CW-1:0] cb, input logic [VAL_W-1:0] vb);
    logic r;
    r = (ca != cb) ? (ca > cb) : (va < vb);
    return r;
  endfunction

  logic [VAL_W-1:0] sample_r;
  logic [CFG_W-1:0] k_r;
  logic [OCC_W-1:0] occ_r;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] idx_r;
  logic [AW-1:0]    clr_addr_r;
  logic [VAL_W-1:0] val_r [MAX_K];
  logic [CW-1:0]    cnt_r [MAX_K];

  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_value_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic                 out_last_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [CW-1:0]    ram_wdata;
  logic [CW-1:0]    ram_rdata;
  logic             sat;
  logic [CW-1:0]    c_new;
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic             room;
  logic             beats_last;
  logic [MAX_K-1:0] up;
  logic             swap;
  logic [CFG_W-1:0] k_eff;
  logic [OCC_W-1:0] n_rep;
  logic             out_free;

  tkft_ram #(
    .WIDTH (CW),
    .DEPTH (VALUE_RANGE)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (AW'(in_sample)),
    .rd_data (ram_rdata)
  );

  assign sat   = (ram_rdata == COUNT_MAX);
  assign c_new = ram_rdata + CW'(1);

  assign ram_we    = cmd.clr_write || (cmd.update && !sat);
  assign ram_waddr = cmd.clr_write ? clr_addr_r : AW'(sample_r);
  assign ram_wdata = cmd.clr_write ? '0 : c_new;

  // Values in the list are unique, so at most one slot matches.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_K; i++) begin
      if ((OCC_W'(i) < occ_r) && (val_r[i] == sample_r)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign room       = (occ_r < OCC_FULL);
  assign beats_last = ranks_before(c_new, sample_r, cnt_r[MAX_K-1], val_r[MAX_K-1]);

  always_comb begin
    up[0] = 1'b0;
    for (int i = 1; i < MAX_K; i++) begin
      up[i] = ranks_before(cnt_r[i], val_r[i], cnt_r[i-1], val_r[i-1]);
    end
  end

  assign swap = up[pos_r];

  // occ_r never exceeds MAX_K, so min(k, occ) already respects MAX_K.
  assign k_eff = (k_r == '0) ? CFG_W'(1) : k_r;
  assign n_rep = (32'(k_eff) < 32'(occ_r)) ? OCC_W'(k_eff) : occ_r;

  assign out_free = !out_valid_r || out_tready;

  assign st.in_range  = (32'(in_sample) < 32'(VALUE_RANGE));
  assign st.clr_last  = (clr_addr_r == CLR_END);
  assign st.placed    = !sat && (hit_any || room || beats_last);
  assign st.swap      = swap;
  assign st.emit_none = (n_rep == '0);
  assign st.emit_last = (OCC_W'(idx_r) == (n_rep - OCC_W'(1)));
  assign st.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= K_RESET;
      occ_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        k_r <= cfg_wr_data;
      end
      if (cmd.clr_write) begin
        occ_r      <= '0;
        clr_addr_r <= st.clr_last ? '0 : clr_addr_r + AW'(1);
      end else if (cmd.update && !sat && !hit_any && room) begin
        occ_r <= occ_r + OCC_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      idx_r    <= '0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + IDX_W'(1);
    end

    if (cmd.update && !sat) begin
      if (hit_any) begin
        cnt_r[hit_idx] <= c_new;
        pos_r          <= hit_idx;
      end else if (room) begin
        val_r[IDX_W'(occ_r)] <= sample_r;
        cnt_r[IDX_W'(occ_r)] <= c_new;
        pos_r                <= IDX_W'(occ_r);
      end else if (beats_last) begin
        val_r[MAX_K-1] <= sample_r;
        cnt_r[MAX_K-1] <= c_new;
        pos_r          <= IDX_TAIL;
      end
    end else if (cmd.bubble && swap) begin
      // swap the tracked slot with its predecessor, follow it forward
      for (int i = 0; i < MAX_K; i++) begin
        if ((i > 0) && (IDX_W'(i) == pos_r)) begin
          val_r[i] <= val_r[(i > 0) ? i - 1 : 0];
          cnt_r[i] <= cnt_r[(i > 0) ? i - 1 : 0];
        end
        if ((i < MAX_K - 1) && (IDX_W'(i + 1) == pos_r)) begin
          val_r[i] <= val_r[(i < MAX_K - 1) ? i + 1 : i];
          cnt_r[i] <= cnt_r[(i < MAX_K - 1) ? i + 1 : i];
        end
      end
      pos_r <= pos_r - IDX_W'(1);
    end

    if (cmd.emit) begin
      out_value_r <= val_r[idx_r];
      out_count_r <= CNT_OUT_W'(cnt_r[idx_r]);
      out_last_r  <= st.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_count_r, out_value_r};
  assign out_tlast  = out_last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL)
    else $error("list occupancy above MAX_K");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_write |=> (occ_r == '0))
    else $error("list not empty after clear step");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (out_free && (OCC_W'(idx_r) < n_rep)))
    else $error("emit into busy output or beyond report length");

  a_swap_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.bubble && swap) |-> (pos_r != '0))
    else $error("swap requested at head of list");

endmodule

/* rtl/core/tkft_ctrl.sv */
// Controller of the top-K frequency tracker: sequences clear sweep, count
// update, bubble steps and the report. Uses tkft_pkg command/status types.
module tkft_ctrl
  import tkft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_mode,
  output logic       in_tready,
  input  tkft_stat_t st,
  output tkft_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_BUB,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_mode) begin
            state_nxt = S_CLEAR;
          end else if (st.in_range) begin
            state_nxt = S_UPD;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = st.placed ? S_BUB : S_EMIT;
      end
      S_BUB: begin
        cmd.bubble = 1'b1;
        if (!st.swap) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.emit_none) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

/* rtl/core/top_k_frequency_tracker_unit.sv */
// Top-K frequency tracker. Each value is accepted, takes an update step and,
// if the update changed the list, bubble steps until it stops climbing (at
// most MAX_K - 1 ranks), then n report beats at one per cycle while the output
// is not stalled (n = min(k_in_use, list size)); an out-of-range value skips
// straight to the report. No new value is taken until the report is done.
// Synchronous reset and each clear item run a sweep over the count table.
module top_k_frequency_tracker_unit
  import tkft_pkg::*;
#(
  parameter int VALUE_RANGE = VALUE_RANGE_DEF,
  parameter int MAX_K       = MAX_K_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] sample_value
  input  logic [0:0]             in_tuser,   // [0] mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] ranked_value, [25:10] ranked_count
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data
);

  tkft_cmd_t  cmd;
  tkft_stat_t st;

  tkft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser[0]),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tkft_dp #(
    .VALUE_RANGE (VALUE_RANGE),
    .MAX_K       (MAX_K),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_sample   (in_tdata[VAL_W-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking bench for top_k_frequency_tracker_unit: streams count and clear beats,
// predicts the ranked report in a scoreboard class and checks every output beat.
// Depends on tkft_pkg and the RTL top only.
`timescale 1ns / 1ps

module tb_top;
  import tkft_pkg::*;

  localparam int SETTLE   = VALUE_RANGE_DEF + 64;  // covers a clear sweep
  localparam int HOLD_LEN = 400;
  localparam int MAX_SHOW = 100;

  typedef struct packed {
    logic [VAL_W-1:0]     value;
    logic [CNT_OUT_W-1:0] count;
    logic                 last;
  } rank_beat_t;

  class rank_scoreboard;
    logic [CNT_OUT_W-1:0] hits [VALUE_RANGE_DEF];
    logic [VAL_W-1:0]     lead_val [MAX_K_DEF];
    logic [CNT_OUT_W-1:0] lead_cnt [MAX_K_DEF];
    int unsigned          lead_size;
    logic [CFG_W-1:0]     k_reg;
    rank_beat_t           due_q [$];
    int unsigned          errors;
    int unsigned          beats_seen;
    int unsigned          counted;
    int unsigned          clears;

    function new();
      clear_all();
      k_reg = K_RESET;
      errors = 0;
      beats_seen = 0;
      counted = 0;
      clears = 0;
    endfunction

    function void clear_all();
      foreach (hits[i]) hits[i] = '0;
      lead_size = 0;
    endfunction

    function bit outranks(logic [CNT_OUT_W-1:0] ca, logic [VAL_W-1:0] va,
                          logic [CNT_OUT_W-1:0] cb, logic [VAL_W-1:0] vb);
      if (ca != cb) return ca > cb;
      return va < vb;
    endfunction

    // move the entry at pos forward while it beats its neighbor
    function void climb(int pos);
      logic [CNT_OUT_W-1:0] c;
      logic [VAL_W-1:0]     v;
      while (pos > 0 && outranks(lead_cnt[pos], lead_val[pos],
                                 lead_cnt[pos-1], lead_val[pos-1])) begin
        c = lead_cnt[pos];
        v = lead_val[pos];
        lead_cnt[pos] = lead_cnt[pos-1];
        lead_val[pos] = lead_val[pos-1];
        lead_cnt[pos-1] = c;
        lead_val[pos-1] = v;
        pos--;
      end
    endfunction

    function void tally(logic [VAL_W-1:0] v);
      if (hits[v] == '1) return;  // saturated: list stays as is
      hits[v] = hits[v] + 1'b1;
      for (int i = 0; i < lead_size; i++) begin
        if (lead_val[i] == v) begin
          lead_cnt[i] = hits[v];
          climb(i);
          return;
        end
      end
      if (lead_size < MAX_K_DEF) begin
        lead_val[lead_size] = v;
        lead_cnt[lead_size] = hits[v];
        lead_size++;
        climb(lead_size - 1);
      end else if (outranks(hits[v], v, lead_cnt[MAX_K_DEF-1], lead_val[MAX_K_DEF-1])) begin
        lead_val[MAX_K_DEF-1] = v;
        lead_cnt[MAX_K_DEF-1] = hits[v];
        climb(MAX_K_DEF - 1);
      end
    endfunction

    function void note_input(logic mode, logic [VAL_W-1:0] v);
      int unsigned n;
      rank_beat_t  b;
      if (mode) begin
        clear_all();
        clears++;
        return;
      end
      tally(v);
      counted++;
      n = (k_reg == 0) ? 1 : 32'(k_reg);
      if (n > MAX_K_DEF) n = MAX_K_DEF;
      if (n > lead_size) n = lead_size;
      for (int i = 0; i < n; i++) begin
        b.value = lead_val[i];
        b.count = lead_cnt[i];
        b.last  = (i + 1 == n);
        due_q.push_back(b);
      end
    endfunction

    task report(string msg);
      if (errors < MAX_SHOW) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data, logic last);
      rank_beat_t want;
      beats_seen++;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected beat value=%0d count=%0d last=%0b",
                         data[9:0], data[25:10], last));
        return;
      end
      want = due_q.pop_front();
      if (data[9:0] != want.value)
        report($sformatf("ranked_value %0d, want %0d", data[9:0], want.value));
      if (data[25:10] != want.count)
        report($sformatf("ranked_count %0d, want %0d", data[25:10], want.count));
      if (last != want.last)
        report($sformatf("last_of_run %0b, want %0b", last, want.last));
    endtask

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  rank_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_ticket    = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  top_k_frequency_tracker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // receiver: random stalls, plus a long hold-off whenever a new ticket shows up
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen  <= hold_ticket;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  task automatic send_item(input logic mode, input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= IN_TDATA_W'(v);
    in_tuser[0] <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(mode, v);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic change_k(input logic [CFG_W-1:0] k);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.k_reg = k;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // mostly a small pool so counts climb and ties happen, some extremes and full range
  task automatic run_random(input int n);
    int               r;
    logic             mode;
    logic [VAL_W-1:0] v;
    repeat (n) begin
      mode = ($urandom_range(99) < 3);
      r = $urandom_range(99);
      if (r < 60) v = VAL_W'($urandom_range(0, 23));
      else if (r < 75) begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = '1;
          2: v = 10'd512;
          default: v = 10'd511;
        endcase
      end else v = VAL_W'($urandom_range(0, VALUE_RANGE_DEF - 1));
      send_item(mode, v);
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ties, filling the list past full, clear, k at reset value
    send_item(1'b0, 10'd0);
    send_item(1'b0, 10'd1023);
    send_item(1'b0, 10'd1023);
    send_item(1'b0, 10'd512);
    send_item(1'b0, 10'd3);
    send_item(1'b0, 10'd5);
    send_item(1'b0, 10'd5);
    for (int i = 100; i < 112; i++) send_item(1'b0, VAL_W'(i));
    send_item(1'b0, 10'd1);
    send_item(1'b0, 10'd2);
    send_item(1'b1, 10'h2AA);
    send_item(1'b0, 10'd7);

    run_random(100);

    change_k(5'd0);
    set_idle(79, 0);
    run_random(80);

    // long receiver hold-off with the sender pushing: input must back up
    change_k(5'd31);
    set_idle(0, 0);
    hold_ticket <= hold_ticket + 1;
    run_random(40);
    set_idle(0, 79);
    run_random(60);

    change_k(5'd7);
    set_idle(27, 27);
    run_random(40);
    wait_drained();
    run_random(40);

    // one value takes the lead from another, reported with k = 1
    change_k(5'd1);
    set_idle(0, 0);
    send_item(1'b1, 10'd0);
    send_item(1'b0, 10'd9);
    repeat (4) send_item(1'b0, 10'd77);
    repeat (3) send_item(1'b0, 10'd9);

    change_k(5'd16);
    set_idle(27, 27);
    run_random(40);

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Counted %0d values and %0d clears, checked %0d ranked beats, %0d mismatches.",
             sb.counted, sb.clears, sb.beats_seen, sb.errors);
    $display("Report lengths 0/1/7/16/31, random stalls both sides, hold-off, lead changes.");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d beats still expected.", sb.pending());
    $display("FAILURE");
    $finish;
  end

endmodule
